// ----- sv/inos_pkg.sv -----
// Shared types, widths and codes for the inverse nonlinear output scaling core.
// No dependencies; every other file refers to this package by scoped names.
package inos_pkg;

    localparam int INPUT_WIDTH = 22;
    // offset sample: wide enough for the sample plus 2^(Bw-1), Bw up to 20
    localparam int V_W = ((INPUT_WIDTH > 21) ? INPUT_WIDTH : 21) + 1;
    localparam int C_W = V_W + 2;
    localparam int X_W = ((V_W + 2) > 44) ? (V_W + 2) : 44;
    localparam int CFG_W = 20;
    localparam int IDX_W = 3;
    localparam int PIPE_DEPTH = 4;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_QUAD   = 2'd1;
    localparam logic [1:0] MODE_EXT    = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [IDX_W-1:0] REG_WORK_BITS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_OUT_DEPTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_QUAD_ALPHA = 3'd3;
    localparam logic [IDX_W-1:0] REG_QUAD_SIGMA = 3'd4;
    localparam logic [IDX_W-1:0] REG_LOW_THR    = 3'd5;
    localparam logic [IDX_W-1:0] REG_HIGH_THR   = 3'd6;
    localparam logic [IDX_W-1:0] REG_SLOPE_EXP  = 3'd7;

    typedef logic signed [V_W-1:0] vval_t;
    typedef logic signed [C_W-1:0] cval_t;
    typedef logic signed [X_W-1:0] xval_t;
    typedef logic signed [X_W:0]   yval_t;

    typedef enum logic [2:0] {
        SEG_LIN,
        SEG_QUAD,
        SEG_LOW,
        SEG_MID,
        SEG_HIGH,
        SEG_NONE
    } seg_t;

    typedef struct packed {
        logic signed [INPUT_WIDTH-1:0] sample;
        logic                          last_in_line;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        line_end;
    } out_item_t;

    // configuration as the datapath sees it, raw and pre-computed
    typedef struct packed {
        logic [1:0]          mode;
        logic [19:0]         half_bw;
        logic [19:0]         t1;
        logic [19:0]         t2;
        logic [19:0]         maxw;
        logic [20:0]         t1s;
        logic signed [21:0]  t2s;
        logic [4:0]          eps;
        logic [15:0]         maxpix;
        logic signed [15:0]  dco;
        logic [4:0]          sh_lin;
        logic [5:0]          sh_quad;
        logic [11:0]         rnd_lin;
        logic [31:0]         rnd_q;
        logic signed [X_W-1:0] base_low;
        logic signed [X_W-1:0] base_high;
        logic signed [X_W-1:0] base_mid;
    } cfg_t;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
    } pipe_en_t;

    // hand-off from the segment stage to the square stage
    typedef struct packed {
        seg_t                seg;
        logic [19:0]         mul;
        logic [39:0]         vsh;
        logic signed [V_W-1:0] v;
        logic                last;
    } mid_item_t;

endpackage

// ----- sv/inos_cfg.sv -----
// Configuration registers and the constants derived from them.
// Depends on inos_pkg.
module inos_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [inos_pkg::IDX_W-1:0]      cfg_index,
    input  logic [inos_pkg::CFG_W-1:0]      cfg_wdata,
    output inos_pkg::cfg_t                  cfg
);

    logic [1:0]  mode_reg;
    logic [4:0]  work_bits_reg;
    logic [4:0]  out_depth_reg;
    logic [14:0] quad_alpha_reg;
    logic        quad_sigma_reg;
    logic [19:0] t1_reg;
    logic [19:0] t2_reg;
    logic [3:0]  slope_reg;

    // first level of derived values
    logic [19:0]        maxw_reg, maxw_next;
    logic [20:0]        t1s_reg, t1s_next;
    logic signed [21:0] t2s_reg, t2s_next;
    logic [4:0]         eps_reg, eps_next;
    logic [15:0]        maxpix_reg, maxpix_next;
    logic signed [15:0] dco_reg, dco_next;
    logic [4:0]         sh_lin_reg, sh_lin_next;
    logic [5:0]         sh_quad_reg, sh_quad_next;
    logic [11:0]        rnd_lin_reg, rnd_lin_next;
    logic [31:0]        rnd_q_reg, rnd_q_next;
    logic [38:0]        sq_reg, sq_next;
    logic [39:0]        t1_sh_reg, t1_sh_next;
    logic [39:0]        t2_sh_reg, t2_sh_next;
    logic [39:0]        b2_reg, b2_next;

    // second level: segment bases with the rounding half folded in
    inos_pkg::xval_t base_low_reg, base_low_next;
    inos_pkg::xval_t base_high_reg, base_high_next;
    inos_pkg::xval_t base_mid_reg, base_mid_next;

    logic [4:0]  bw;
    logic [4:0]  dep;
    logic [4:0]  e_cap;
    logic [4:0]  e_sat;
    logic [19:0] s_half;
    logic [5:0]  sq_exp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= inos_pkg::MODE_LINEAR;
            work_bits_reg  <= 5'd20;
            out_depth_reg  <= 5'd8;
            quad_alpha_reg <= '0;
            quad_sigma_reg <= 1'b0;
            t1_reg         <= '0;
            t2_reg         <= '0;
            slope_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                inos_pkg::REG_MODE:       mode_reg       <= cfg_wdata[1:0];
                inos_pkg::REG_WORK_BITS:  work_bits_reg  <= cfg_wdata[4:0];
                inos_pkg::REG_OUT_DEPTH:  out_depth_reg  <= cfg_wdata[4:0];
                inos_pkg::REG_QUAD_ALPHA: quad_alpha_reg <= cfg_wdata[14:0];
                inos_pkg::REG_QUAD_SIGMA: quad_sigma_reg <= cfg_wdata[0];
                inos_pkg::REG_LOW_THR:    t1_reg         <= cfg_wdata[19:0];
                inos_pkg::REG_HIGH_THR:   t2_reg         <= cfg_wdata[19:0];
                inos_pkg::REG_SLOPE_EXP:  slope_reg      <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        bw = (work_bits_reg < 5'd8) ? 5'd8 :
             (work_bits_reg > 5'd20) ? 5'd20 : work_bits_reg;
        dep = (out_depth_reg < 5'd8) ? 5'd8 :
              (out_depth_reg > 5'd16) ? 5'd16 : out_depth_reg;
        e_cap = bw - 5'd2;
        e_sat = ({1'b0, slope_reg} > e_cap) ? e_cap : {1'b0, slope_reg};
        eps_next = bw - e_sat;
        s_half = 20'd1 << (eps_next - 5'd1);
        sq_exp = {eps_next, 1'b0} - 6'd2;

        maxw_next    = 20'hFFFFF >> (5'd20 - bw);
        maxpix_next  = 16'hFFFF >> (5'd16 - dep);
        sh_lin_next  = (bw > dep) ? (bw - dep) : 5'd0;
        sh_quad_next = {bw, 1'b0} - {1'b0, dep};
        rnd_lin_next = (sh_lin_next == 5'd0) ? 12'd0 : (12'd1 << (sh_lin_next - 5'd1));
        rnd_q_next   = (sh_quad_next == 6'd0) ? 32'd0 : (32'd1 << (sh_quad_next - 6'd1));
        t1s_next     = {1'b0, t1_reg} + {1'b0, s_half};
        t2s_next     = $signed({2'b00, t2_reg}) - $signed({2'b00, s_half});
        sq_next      = 39'd1 << sq_exp;
        t1_sh_next   = {20'd0, t1_reg} << eps_next;
        t2_sh_next   = {20'd0, t2_reg} << eps_next;
        b2_next      = {20'd0, t1_reg} * {20'd0, t1_reg};
        dco_next     = $signed({quad_sigma_reg, quad_alpha_reg});

        base_low_next  = inos_pkg::xval_t'(b2_reg) + inos_pkg::xval_t'(t1_sh_reg)
                       + inos_pkg::xval_t'(sq_reg) + inos_pkg::xval_t'(rnd_q_reg);
        base_high_next = inos_pkg::xval_t'(b2_reg) + inos_pkg::xval_t'(t2_sh_reg)
                       + inos_pkg::xval_t'(rnd_q_reg) - inos_pkg::xval_t'(sq_reg);
        base_mid_next  = inos_pkg::xval_t'(b2_reg) + inos_pkg::xval_t'(rnd_q_reg);
    end

    always_ff @(posedge aclk) begin
        maxw_reg      <= maxw_next;
        t1s_reg       <= t1s_next;
        t2s_reg       <= t2s_next;
        eps_reg       <= eps_next;
        maxpix_reg    <= maxpix_next;
        dco_reg       <= dco_next;
        sh_lin_reg    <= sh_lin_next;
        sh_quad_reg   <= sh_quad_next;
        rnd_lin_reg   <= rnd_lin_next;
        rnd_q_reg     <= rnd_q_next;
        sq_reg        <= sq_next;
        t1_sh_reg     <= t1_sh_next;
        t2_sh_reg     <= t2_sh_next;
        b2_reg        <= b2_next;
        base_low_reg  <= base_low_next;
        base_high_reg <= base_high_next;
        base_mid_reg  <= base_mid_next;
    end

    always_comb begin
        cfg.mode      = mode_reg;
        cfg.half_bw   = 20'd1 << (bw - 5'd1);
        cfg.t1        = t1_reg;
        cfg.t2        = t2_reg;
        cfg.maxw      = maxw_reg;
        cfg.t1s       = t1s_reg;
        cfg.t2s       = t2s_reg;
        cfg.eps       = eps_reg;
        cfg.maxpix    = maxpix_reg;
        cfg.dco       = dco_reg;
        cfg.sh_lin    = sh_lin_reg;
        cfg.sh_quad   = sh_quad_reg;
        cfg.rnd_lin   = rnd_lin_reg;
        cfg.rnd_q     = rnd_q_reg;
        cfg.base_low  = base_low_reg;
        cfg.base_high = base_high_reg;
        cfg.base_mid  = base_mid_reg;
    end

endmodule

// ----- sv/inos_front.sv -----
// Input register and segment stage: DC offset, segment choice, square operand.
// Depends on inos_pkg.
module inos_front (
    input  logic                 aclk,
    input  inos_pkg::pipe_en_t   en,
    input  inos_pkg::in_item_t   s_data,
    input  inos_pkg::cfg_t       cfg,
    output inos_pkg::mid_item_t  mid
);

    inos_pkg::vval_t     v_a_reg;
    logic                last_a_reg;
    inos_pkg::mid_item_t mid_reg, mid_next;

    logic                lt1;
    logic                lt2;
    inos_pkg::cval_t     c_quad;
    inos_pkg::cval_t     c_low;
    inos_pkg::cval_t     c_high;
    inos_pkg::cval_t     c_raw;

    // offset by 2^(Bw-1) on the way in
    always_ff @(posedge aclk) begin
        if (en.a) begin
            v_a_reg    <= inos_pkg::vval_t'(s_data.sample) + inos_pkg::vval_t'(cfg.half_bw);
            last_a_reg <= s_data.last_in_line;
        end
    end

    always_comb begin
        lt1    = v_a_reg < inos_pkg::vval_t'(cfg.t1);
        lt2    = v_a_reg < inos_pkg::vval_t'(cfg.t2);
        c_quad = inos_pkg::cval_t'(v_a_reg);
        c_low  = inos_pkg::cval_t'(cfg.t1s) - inos_pkg::cval_t'(v_a_reg);
        c_high = inos_pkg::cval_t'(v_a_reg) - inos_pkg::cval_t'(cfg.t2s);

        mid_next.v    = v_a_reg;
        mid_next.last = last_a_reg;
        case (cfg.mode)
            inos_pkg::MODE_LINEAR: begin
                mid_next.seg = inos_pkg::SEG_LIN;
                c_raw        = '0;
            end
            inos_pkg::MODE_QUAD: begin
                mid_next.seg = inos_pkg::SEG_QUAD;
                c_raw        = c_quad;
            end
            inos_pkg::MODE_EXT: begin
                if (lt1) begin
                    mid_next.seg = inos_pkg::SEG_LOW;
                    c_raw        = c_low;
                end else if (lt2) begin
                    mid_next.seg = inos_pkg::SEG_MID;
                    c_raw        = '0;
                end else begin
                    mid_next.seg = inos_pkg::SEG_HIGH;
                    c_raw        = c_high;
                end
            end
            default: begin
                mid_next.seg = inos_pkg::SEG_NONE;
                c_raw        = '0;
            end
        endcase

        // clamp the square operand to 0..2^Bw-1
        if (c_raw < 0) begin
            mid_next.mul = '0;
        end else if (c_raw > inos_pkg::cval_t'(cfg.maxw)) begin
            mid_next.mul = cfg.maxw;
        end else begin
            mid_next.mul = c_raw[19:0];
        end

        // in the linear segment v lies in 0..t2-1, so 20 bits carry it
        if (mid_next.seg == inos_pkg::SEG_MID) begin
            mid_next.vsh = {20'd0, v_a_reg[19:0]} << cfg.eps;
        end else begin
            mid_next.vsh = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.b) begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

// ----- sv/inos_back.sv -----
// Square stage and output stage: square, segment base, round, offset, saturate.
// Depends on inos_pkg.
module inos_back (
    input  logic                 aclk,
    input  inos_pkg::pipe_en_t   en,
    input  inos_pkg::mid_item_t  mid,
    input  inos_pkg::cfg_t       cfg,
    output inos_pkg::out_item_t  m_data
);

    logic [39:0]         prod_reg, prod_next;
    inos_pkg::xval_t     base_reg, base_next;
    inos_pkg::seg_t      seg_reg;
    logic                last_reg;
    inos_pkg::out_item_t out_reg, out_next;

    inos_pkg::xval_t     x;
    inos_pkg::xval_t     y;
    inos_pkg::yval_t     yq;
    logic [5:0]          sh;

    always_comb begin
        prod_next = {20'd0, mid.mul} * {20'd0, mid.mul};
        case (mid.seg)
            inos_pkg::SEG_LIN:  base_next = inos_pkg::xval_t'(mid.v)
                                          + inos_pkg::xval_t'(cfg.rnd_lin);
            inos_pkg::SEG_QUAD: base_next = inos_pkg::xval_t'(cfg.rnd_q);
            inos_pkg::SEG_LOW:  base_next = cfg.base_low;
            inos_pkg::SEG_MID:  base_next = cfg.base_mid + inos_pkg::xval_t'(mid.vsh);
            inos_pkg::SEG_HIGH: base_next = cfg.base_high;
            default:            base_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.c) begin
            prod_reg <= prod_next;
            base_reg <= base_next;
            seg_reg  <= mid.seg;
            last_reg <= mid.last;
        end
    end

    always_comb begin
        // the mirrored square below t1 subtracts
        if (seg_reg == inos_pkg::SEG_LOW) begin
            x = base_reg - inos_pkg::xval_t'(prod_reg);
        end else begin
            x = base_reg + inos_pkg::xval_t'(prod_reg);
        end
        sh = (seg_reg == inos_pkg::SEG_LIN) ? {1'b0, cfg.sh_lin} : cfg.sh_quad;
        y  = x >>> sh;
        if (seg_reg == inos_pkg::SEG_QUAD) begin
            yq = inos_pkg::yval_t'(y) + inos_pkg::yval_t'(cfg.dco);
        end else begin
            yq = inos_pkg::yval_t'(y);
        end

        out_next.line_end = last_reg;
        if (seg_reg == inos_pkg::SEG_NONE || yq < 0) begin
            out_next.pixel = '0;
        end else if (yq > inos_pkg::yval_t'(cfg.maxpix)) begin
            out_next.pixel = cfg.maxpix;
        end else begin
            out_next.pixel = yq[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.d) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// ----- sv/inverse_nonlinear_output_scaling_core.sv -----
// Inverse nonlinear output scaling core: top level with handshake and pipeline control.
// Depends on inos_pkg, inos_cfg, inos_front and inos_back.
//
// Maps each signed reconstructed sample to an unsigned pixel of 8..16 bits with
// linear, quadratic or extended piecewise scaling, saturating to 0..2^depth-1; the
// line-end mark travels with its sample. The datapath is a four-register pipeline
// (input, segment, square, output) that takes one sample per clock unless a stalled
// output has filled every stage; the single 20x20 square sits in the third stage.
// Each stage moves on as soon as the one after it has room, so a stalled output
// stops intake only once every stage is full. Configuration writes take effect for a
// sample transferred on the very next cycle; settings derived from them are registered
// in inos_cfg, first the derived values and then the segment bases built from them.
module inverse_nonlinear_output_scaling_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  inos_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output inos_pkg::out_item_t         m_data,
    input  logic                        cfg_wr_en,
    input  logic [inos_pkg::IDX_W-1:0]  cfg_index,
    input  logic [inos_pkg::CFG_W-1:0]  cfg_wdata
);

    inos_pkg::cfg_t      cfg;
    inos_pkg::pipe_en_t  en;
    inos_pkg::mid_item_t mid;

    logic va_reg;
    logic vb_reg;
    logic vc_reg;
    logic vd_reg;

    // a stage advances when it is empty or its successor advances
    always_comb begin
        en.d = !vd_reg || m_ready;
        en.c = !vc_reg || en.d;
        en.b = !vb_reg || en.c;
        en.a = !va_reg || en.b;
    end

    assign s_ready = en.a;
    assign m_valid = vd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (en.a) begin
                va_reg <= s_valid;
            end
            if (en.b) begin
                vb_reg <= va_reg;
            end
            if (en.c) begin
                vc_reg <= vb_reg;
            end
            if (en.d) begin
                vd_reg <= vc_reg;
            end
        end
    end

    inos_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    inos_front u_front (
        .aclk   (aclk),
        .en     (en),
        .s_data (s_data),
        .cfg    (cfg),
        .mid    (mid)
    );

    inos_back u_back (
        .aclk   (aclk),
        .en     (en),
        .mid    (mid),
        .cfg    (cfg),
        .m_data (m_data)
    );

endmodule

// ----- sv/inos_checker.sv -----
// Port-level checks for the output scaling core, attached by bind.
// Depends on inos_pkg and inverse_nonlinear_output_scaling_core.
module inos_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input inos_pkg::out_item_t         m_data,
    input logic                        cfg_wr_en,
    input logic [inos_pkg::IDX_W-1:0]  cfg_index,
    input logic [inos_pkg::CFG_W-1:0]  cfg_wdata
);

    logic [1:0]  mode_reg;
    logic [4:0]  depth_reg;
    logic [2:0]  inflight_reg, inflight_next;
    logic [4:0]  dep;
    logic [15:0] maxpix;
    logic        s_xfer;
    logic        m_xfer;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg + {2'b00, s_xfer} - {2'b00, m_xfer};
        dep = (depth_reg < 5'd8) ? 5'd8 : (depth_reg > 5'd16) ? 5'd16 : depth_reg;
        maxpix = 16'hFFFF >> (5'd16 - dep);
    end

    // shadow the registers that bound the pixel range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= inos_pkg::MODE_LINEAR;
            depth_reg    <= 5'd8;
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
            if (cfg_wr_en && cfg_index == inos_pkg::REG_MODE) begin
                mode_reg <= cfg_wdata[1:0];
            end
            if (cfg_wr_en && cfg_index == inos_pkg::REG_OUT_DEPTH) begin
                depth_reg <= cfg_wdata[4:0];
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("intake stalled without a waiting result");

    a_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg <= 3'(inos_pkg::PIPE_DEPTH)) && (!m_valid || inflight_reg != 3'd0))
        else $error("result count does not match transfers");

    a_pixel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pixel <= maxpix)
                    && (mode_reg != inos_pkg::MODE_NONE || m_data.pixel == 16'd0))
        else $error("pixel outside the configured range");

endmodule

bind inverse_nonlinear_output_scaling_core inos_checker u_inos_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for inverse_nonlinear_output_scaling_core: a directed table,
// then randomized phases under several idle patterns. Depends on inos_pkg and the core.
module testbench;

    localparam int     LONG_HOLD   = 64;
    localparam int     RAND_PHASES = 12;
    localparam int     PHASE_ITEMS = 58;
    localparam longint SIGMA_STEP  = longint'(1) << 15;
    localparam int     IN_W        = inos_pkg::INPUT_WIDTH;
    localparam int     CFG_BITS    = inos_pkg::CFG_W;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  work_bits;
        logic [4:0]  out_depth;
        logic [14:0] alpha;
        logic        sigma;
        logic [19:0] t1;
        logic [19:0] t2;
        logic [3:0]  slope;
    } scale_cfg_t;

    typedef struct packed {
        logic [2:0]             preset;
        logic signed [IN_W-1:0] sample;
        logic                   last;
        logic                   known;
        logic [15:0]            pixel;
    } directed_row_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    inos_pkg::in_item_t         s_data    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    inos_pkg::out_item_t        m_data;
    logic                       cfg_wr_en = 1'b0;
    logic [inos_pkg::IDX_W-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]        cfg_wdata = '0;

    scale_cfg_t          active_cfg;
    inos_pkg::out_item_t expected_pixels[$];
    int                  fail_count      = 0;
    int                  sender_idle_pct = 32;
    int                  stall_pct       = 32;
    int                  hold_req        = 0;
    int                  hold_seen       = 0;
    int                  hold_left       = 0;

    // preset 0 matches the reset state and is never written
    scale_cfg_t presets [8] = '{
        '{inos_pkg::MODE_LINEAR, 5'd20, 5'd8,  15'd0,    1'b0, 20'd0,      20'd0,      4'd0},
        '{inos_pkg::MODE_QUAD,   5'd20, 5'd16, 15'h7FFF, 1'b0, 20'd0,      20'd0,      4'd0},
        '{inos_pkg::MODE_QUAD,   5'd8,  5'd8,  15'd0,    1'b1, 20'd0,      20'd0,      4'd0},
        '{inos_pkg::MODE_EXT,    5'd20, 5'd16, 15'd0,    1'b0, 20'd300000, 20'd700000, 4'd4},
        '{inos_pkg::MODE_EXT,    5'd20, 5'd12, 15'd0,    1'b0, 20'd600000, 20'd200000, 4'd15},
        '{inos_pkg::MODE_NONE,   5'd20, 5'd8,  15'd0,    1'b0, 20'd0,      20'd0,      4'd0},
        '{inos_pkg::MODE_LINEAR, 5'd5,  5'd20, 15'd0,    1'b0, 20'd0,      20'd0,      4'd0},
        '{inos_pkg::MODE_LINEAR, 5'd31, 5'd3,  15'd0,    1'b0, 20'd0,      20'd0,      4'd0}
    };

    directed_row_t directed_rows [26] = '{
        '{3'd0, 22'sd0,         1'b0, 1'b1, 16'd128},
        '{3'd0, -22'sd524288,   1'b0, 1'b1, 16'd0},
        '{3'd0, 22'sd524287,    1'b0, 1'b1, 16'd255},
        '{3'd0, 22'h200000,     1'b0, 1'b1, 16'd0},
        '{3'd0, 22'sd2097151,   1'b1, 1'b1, 16'd255},
        '{3'd0, -22'sd2048,     1'b0, 1'b1, 16'd128},
        '{3'd0, -22'sd2049,     1'b1, 1'b1, 16'd127},
        '{3'd1, -22'sd524288,   1'b0, 1'b0, 16'd0},
        '{3'd1, 22'sd0,         1'b0, 1'b0, 16'd0},
        '{3'd1, 22'sd524287,    1'b1, 1'b0, 16'd0},
        '{3'd1, 22'h200000,     1'b0, 1'b0, 16'd0},
        '{3'd2, 22'sd0,         1'b0, 1'b1, 16'd0},
        '{3'd2, 22'sd127,       1'b1, 1'b1, 16'd0},
        '{3'd3, -22'sd424288,   1'b0, 1'b0, 16'd0},
        '{3'd3, -22'sd24288,    1'b0, 1'b0, 16'd0},
        '{3'd3, 22'sd375712,    1'b0, 1'b0, 16'd0},
        '{3'd3, -22'sd224288,   1'b0, 1'b0, 16'd0},
        '{3'd3, 22'sd175712,    1'b1, 1'b0, 16'd0},
        '{3'd4, -22'sd224288,   1'b0, 1'b0, 16'd0},
        '{3'd4, 22'sd175712,    1'b1, 1'b0, 16'd0},
        '{3'd5, 22'sd12345,     1'b1, 1'b1, 16'd0},
        '{3'd6, 22'sd0,         1'b0, 1'b1, 16'd128},
        '{3'd6, 22'sd1000,      1'b0, 1'b1, 16'd1128},
        '{3'd6, 22'sd100000,    1'b0, 1'b1, 16'd65535},
        '{3'd6, -22'sd129,      1'b1, 1'b1, 16'd0},
        '{3'd7, 22'sd0,         1'b0, 1'b1, 16'd128}
    };

    inverse_nonlinear_output_scaling_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint clamp_to(longint val, longint hi);
        return (val > hi) ? hi : ((val < 0) ? longint'(0) : val);
    endfunction

    // round half up, then floor shift
    function automatic longint round_down(longint val, longint sh);
        return (sh == 0) ? val : ((val + (longint'(1) << (sh - 1))) >>> sh);
    endfunction

    function automatic inos_pkg::out_item_t scale_pixel(scale_cfg_t c,
                                                        inos_pkg::in_item_t it);
        longint              bw, d, maxpix, maxw, v, dz2, r, e, eps, s, sq, t1, t2, x, cl;
        inos_pkg::out_item_t o;
        bw = clamp_to(longint'(c.work_bits), 20);
        if (bw < 8) bw = 8;
        d = clamp_to(longint'(c.out_depth), 16);
        if (d < 8) d = 8;
        maxpix = (longint'(1) << d) - 1;
        maxw   = (longint'(1) << bw) - 1;
        dz2    = 2 * bw - d;
        v      = longint'(it.sample) + (longint'(1) << (bw - 1));
        r      = 0;
        case (c.mode)
            inos_pkg::MODE_LINEAR: begin
                r = clamp_to(round_down(v, (bw > d) ? bw - d : longint'(0)), maxpix);
            end
            inos_pkg::MODE_QUAD: begin
                cl = clamp_to(v, maxw);
                r  = clamp_to(round_down(cl * cl, dz2) + longint'(c.alpha)
                              - (c.sigma ? SIGMA_STEP : longint'(0)), maxpix);
            end
            inos_pkg::MODE_EXT: begin
                e   = (longint'(c.slope) > bw - 2) ? bw - 2 : longint'(c.slope);
                eps = bw - e;
                s   = longint'(1) << (eps - 1);
                sq  = longint'(1) << (2 * eps - 2);
                t1  = longint'(c.t1);
                t2  = longint'(c.t2);
                if (v < t1) begin
                    cl = clamp_to(t1 + s - v, maxw);
                    x  = t1 * t1 + (t1 << eps) + sq - cl * cl;
                end else if (v < t2) begin
                    x = (v << eps) + t1 * t1;
                end else begin
                    cl = clamp_to(v - (t2 - s), maxw);
                    x  = t1 * t1 + (t2 << eps) - sq + cl * cl;
                end
                r = clamp_to(round_down(x, dz2), maxpix);
            end
            default: r = 0;
        endcase
        o.pixel    = r[15:0];
        o.line_end = it.last_in_line;
        return o;
    endfunction

    function automatic int eff_bits(logic [4:0] wb);
        return (wb < 8) ? 8 : ((wb > 20) ? 20 : int'(wb));
    endfunction

    // mostly samples inside the working window, some near thresholds, some anywhere
    function automatic logic signed [IN_W-1:0] pick_sample(scale_cfg_t c);
        int half, pick, thr;
        half = 1 << (eff_bits(c.work_bits) - 1);
        pick = $urandom_range(9);
        if (pick < 3)
            return IN_W'($urandom);
        if (pick < 5 && c.mode == inos_pkg::MODE_EXT) begin
            thr = (pick == 3) ? int'(c.t1) : int'(c.t2);
            return IN_W'(thr - half + int'($urandom_range(8)) - 4);
        end
        return IN_W'(int'($urandom_range(5 * half / 2)) - (5 * half / 4));
    endfunction

    function automatic scale_cfg_t random_config(int kind);
        scale_cfg_t c;
        int         lim, a, b;
        case (kind)
            0: c = '{inos_pkg::MODE_QUAD, 5'd20, 5'd16, 15'h7FFF, 1'b1,
                     20'hFFFFF, 20'hFFFFF, 4'hF};
            1: c = '{inos_pkg::MODE_LINEAR, 5'd0, 5'd0, 15'd0, 1'b0,
                     20'd0, 20'd0, 4'd0};
            2: c = '{inos_pkg::MODE_EXT, 5'd20, 5'd16, 15'd0, 1'b0,
                     20'hFFFFF, 20'hFFFFF, 4'hF};
            default: begin
                case ($urandom_range(11))
                    0:          c.mode = inos_pkg::MODE_NONE;
                    1, 2, 3:    c.mode = inos_pkg::MODE_LINEAR;
                    4, 5, 6, 7: c.mode = inos_pkg::MODE_QUAD;
                    default:    c.mode = inos_pkg::MODE_EXT;
                endcase
                c.work_bits = ($urandom_range(7) == 0) ? 5'($urandom)
                                                       : 5'($urandom_range(20, 8));
                c.out_depth = ($urandom_range(7) == 0) ? 5'($urandom)
                                                       : 5'($urandom_range(16, 8));
                c.alpha = 15'($urandom);
                c.sigma = 1'($urandom);
                c.slope = 4'($urandom);
                lim = eff_bits(c.work_bits);
                a = $urandom_range((1 << lim) - 1);
                b = $urandom_range((1 << lim) - 1);
                // keep t1 <= t2 most of the time
                if (a > b && $urandom_range(4) != 0) {a, b} = {b, a};
                c.t1 = 20'(a);
                c.t2 = 20'(b);
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [inos_pkg::IDX_W-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_config(input scale_cfg_t c);
        write_reg(inos_pkg::REG_MODE,       CFG_BITS'(c.mode));
        write_reg(inos_pkg::REG_WORK_BITS,  CFG_BITS'(c.work_bits));
        write_reg(inos_pkg::REG_OUT_DEPTH,  CFG_BITS'(c.out_depth));
        write_reg(inos_pkg::REG_QUAD_ALPHA, CFG_BITS'(c.alpha));
        write_reg(inos_pkg::REG_QUAD_SIGMA, CFG_BITS'(c.sigma));
        write_reg(inos_pkg::REG_LOW_THR,    CFG_BITS'(c.t1));
        write_reg(inos_pkg::REG_HIGH_THR,   CFG_BITS'(c.t2));
        write_reg(inos_pkg::REG_SLOPE_EXP,  CFG_BITS'(c.slope));
        cfg_wr_en  <= 1'b0;
        active_cfg = c;
    endtask

    // drop valid, then let the pipeline empty before touching the registers
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (inos_pkg::PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic send_item(input inos_pkg::in_item_t it, input logic known,
                             input inos_pkg::out_item_t known_res);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_pixels.push_back(known ? known_res : scale_pixel(active_cfg, it));
    endtask

    task automatic report_fault(input string what, input inos_pkg::out_item_t want,
                                input inos_pkg::out_item_t got);
        if (fail_count < 10)
            $display("%0t %s: expected pixel %0d line_end %0b, got pixel %0d line_end %0b",
                     $time, what, want.pixel, want.line_end, got.pixel, got.line_end);
        fail_count++;
    endtask

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : pixel_check
        inos_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                want = '0;
                report_fault("unexpected transfer", want, m_data);
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.pixel !== want.pixel || m_data.line_end !== want.line_end)
                    report_fault("pixel mismatch", want, m_data);
            end
        end
    end

    initial begin : stimulus
        inos_pkg::in_item_t  it;
        inos_pkg::out_item_t known_res;
        int                  cur_preset;
        active_cfg = presets[0];
        cur_preset = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (int'(directed_rows[i].preset) != cur_preset) begin
                wait_drained();
                cur_preset = directed_rows[i].preset;
                load_config(presets[cur_preset]);
            end
            it.sample          = directed_rows[i].sample;
            it.last_in_line    = directed_rows[i].last;
            known_res.pixel    = directed_rows[i].pixel;
            known_res.line_end = directed_rows[i].last;
            send_item(it, directed_rows[i].known, known_res);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            load_config(random_config(p));
            case (p % 4)
                0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
                1:       begin sender_idle_pct = 79; stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  stall_pct = 79; end
                default: begin sender_idle_pct = 32; stall_pct = 32; end
            endcase
            // back up the pipeline while the sender keeps streaming
            if (p % 4 == 0 && p > 0) hold_req++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it.sample       = pick_sample(active_cfg);
                it.last_in_line = ($urandom_range(7) == 0);
                send_item(it, 1'b0, '0);
            end
        end

        wait_drained();
        fail_count += expected_pixels.size();
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
